// File: design/nearest_palette_color_search_assert.svh
// Assertion macros shared by the checker of the nearest palette color search.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH

// Implication checked in the same cycle, suspended while reset is held.
`define NPCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("npcs check failed");

// Implication checked in the next cycle, suspended while reset is held.
`define NPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("npcs check failed");

// Implication checked in the next cycle, also during reset.
`define NPCS_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("npcs check failed");

`endif

// File: design/npcs_pkg.sv
// Types, constants and palette expansion functions of the nearest palette color search.
package npcs_pkg;

    localparam int ColorW    = 8;
    localparam int RgbW      = 3 * ColorW;
    localparam int NumBases  = 4;
    localparam int BaseW     = 2;
    localparam int LevelMaxW = 6;
    localparam int DistW     = 18;

    localparam logic [ColorW-1:0]    ChanMax     = 8'd255;
    localparam logic [DistW-1:0]     StartDist   = 18'(3 * (255 * 255));
    localparam logic [LevelMaxW-1:0] ActiveLimit = 6'd8;

    typedef struct packed {
        logic [ColorW-1:0] red;
        logic [ColorW-1:0] green;
        logic [ColorW-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic       hue_pair;
        logic       color_number;
        logic [3:0] bright_level;
        logic       active;
    } t_result;

    typedef struct packed {
        logic             we;
        logic [BaseW-1:0] idx;
        logic [RgbW-1:0]  data;
    } t_cfg_wr;

    // Word travelling down the cell row, with the best match found so far.
    typedef struct packed {
        logic                 valid;
        t_pixel               pix;
        logic [DistW-1:0]     best_dist;
        logic [BaseW-1:0]     best_base;
        logic [LevelMaxW-1:0] best_level;
    } t_token;

    // One channel of a level: base + ((255 - base) / 16) * level, saturated at 255.
    function automatic logic [ColorW-1:0] expand_channel(input logic [ColorW-1:0] base,
                                                         input logic [LevelMaxW-1:0] level);
        logic [ColorW-1:0] room;
        logic [3:0]        step;
        logic [10:0]       sum;
        room = ChanMax - base;
        step = room[7:4];
        sum  = {3'b000, base} + 11'({6'b000000, step} * {4'b0000, level});
        return (sum > {3'b000, ChanMax}) ? ChanMax : sum[ColorW-1:0];
    endfunction

    function automatic logic [RgbW-1:0] expand_rgb(input logic [RgbW-1:0] base,
                                                   input logic [LevelMaxW-1:0] level);
        return {expand_channel(base[23:16], level),
                expand_channel(base[15:8], level),
                expand_channel(base[7:0], level)};
    endfunction

endpackage

// File: design/npcs_chan_if.sv
// Valid/ready channel carrying one payload word per handshake.
interface npcs_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/npcs_cell.sv
// One palette entry cell: holds its color and updates the running best match.
module npcs_cell #(
    parameter int BASE_ID = 0,
    parameter int LEVEL   = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  npcs_pkg::t_cfg_wr  i_cfg,
    input  npcs_pkg::t_token   i_tok,
    output npcs_pkg::t_token   o_tok
);
    localparam logic [npcs_pkg::LevelMaxW-1:0] Lvl    = npcs_pkg::LevelMaxW'(LEVEL);
    localparam logic [npcs_pkg::BaseW-1:0]     BaseId = npcs_pkg::BaseW'(BASE_ID);

    logic [npcs_pkg::RgbW-1:0] r_entry;
    npcs_pkg::t_token          r_tok;
    npcs_pkg::t_token          n_tok;

    logic [7:0]                 dr, dg, db;
    logic [15:0]                sr, sg, sb;
    logic [npcs_pkg::DistW-1:0] cand_dist;

    always_comb begin
        dr = (r_entry[23:16] > i_tok.pix.red) ? r_entry[23:16] - i_tok.pix.red
                                              : i_tok.pix.red - r_entry[23:16];
        dg = (r_entry[15:8] > i_tok.pix.green) ? r_entry[15:8] - i_tok.pix.green
                                               : i_tok.pix.green - r_entry[15:8];
        db = (r_entry[7:0] > i_tok.pix.blue) ? r_entry[7:0] - i_tok.pix.blue
                                             : i_tok.pix.blue - r_entry[7:0];
        sr        = {8'h00, dr} * {8'h00, dr};
        sg        = {8'h00, dg} * {8'h00, dg};
        sb        = {8'h00, db} * {8'h00, db};
        cand_dist = {2'b00, sr} + {2'b00, sg} + {2'b00, sb};

        n_tok = i_tok;
        // Only a strictly closer entry wins, so earlier cells keep ties.
        if (cand_dist < i_tok.best_dist) begin
            n_tok.best_dist  = cand_dist;
            n_tok.best_base  = BaseId;
            n_tok.best_level = Lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= npcs_pkg::expand_rgb('0, Lvl);
        end else if (i_cfg.we && (i_cfg.idx == BaseId)) begin
            r_entry <= npcs_pkg::expand_rgb(i_cfg.data, Lvl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_advance) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
endmodule

// File: design/nearest_palette_color_search.sv
// Top level of the nearest palette color search: a row of palette entry cells.
// Each pixel word is registered in each of the 4 * LEVELS cells in turn, and its result word
// is presented from the register of the last cell, which doubles as the output register.
// Throughput: one pixel word per cycle; the row of 4 * LEVELS cells is a pipeline
// that stalls as a whole only while the result at its end is not taken.
// Reset: clears every cell's valid flag and loads the palette derived from
// all-zero base colors in the same cycle; no clearing pass follows.
module nearest_palette_color_search #(
    parameter int LEVELS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [npcs_pkg::BaseW-1:0]           i_cfg_idx,
    input  logic [npcs_pkg::RgbW-1:0]            i_cfg_data,
    npcs_chan_if.sink                            i_pix,
    npcs_chan_if.source                          o_res
);
    localparam int NumCells = npcs_pkg::NumBases * LEVELS;

    npcs_pkg::t_cfg_wr cfg;
    npcs_pkg::t_token  chain [0:NumCells];
    logic              advance;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // The last cell register doubles as the output register.
    assign advance     = !chain[NumCells].valid || o_res.ready;
    assign i_pix.ready = advance;

    assign chain[0].valid      = i_pix.valid;
    assign chain[0].pix        = i_pix.data;
    assign chain[0].best_dist  = npcs_pkg::StartDist;
    assign chain[0].best_base  = '0;
    assign chain[0].best_level = '0;

    for (genvar gi = 0; gi < NumCells; gi++) begin : g_cell
        localparam int BaseId = gi / LEVELS;
        localparam int Level  = gi % LEVELS;
        npcs_cell #(
            .BASE_ID (BaseId),
            .LEVEL   (Level)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_cfg     (cfg),
            .i_tok     (chain[gi]),
            .o_tok     (chain[gi+1])
        );
    end

    assign o_res.valid             = chain[NumCells].valid;
    assign o_res.data.hue_pair     = chain[NumCells].best_base[1];
    assign o_res.data.color_number = chain[NumCells].best_base[0];
    assign o_res.data.bright_level = chain[NumCells].best_level[3:0];
    assign o_res.data.active       = chain[NumCells].best_level < npcs_pkg::ActiveLimit;
endmodule

// File: design/npcs_checker.sv
// Port-level checker of the nearest palette color search and its bind.
`include "nearest_palette_color_search_assert.svh"

module npcs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input npcs_pkg::t_result i_out_data
);
    // The row moves whenever its end is empty or being drained.
    `NPCS_ASSERT_NOW(a_ready_when_free, i_clk, i_rst_n, !i_out_valid || i_out_ready, i_in_ready)
    // A stalled end of the row blocks new input.
    `NPCS_ASSERT_NOW(a_block_when_stalled, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready)
    // A stalled result word holds its value.
    `NPCS_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                      i_out_valid && $stable(i_out_data))
    // Reset empties the row.
    `NPCS_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)
endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
